>>> hdl/sha256_pkg.sv
// Package: SHA-256 hasher types, constants and round functions.
`default_nettype none
package sha256_pkg;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } t_item;

    typedef logic [31:0] t_word;

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word ror(input t_word x, input int unsigned r);
        ror = (x >> r) | (x << (32 - r));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction
endpackage
`default_nettype wire

>>> hdl/sha256_queue.sv
// Short FIFO between the input front end and the hashing engine.
`default_nettype none
module sha256_queue #(
    parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire sha256_pkg::t_item i_item,
    output logic                o_full,
    input  wire                 i_pop,
    output sha256_pkg::t_item   o_item,
    output logic                o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

>>> hdl/sha256_engine.sv
// Compression datapath: schedule window, working words, round unit, chaining words.
`default_nettype none
module sha256_engine (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  wire  [3:0]         i_addr,
    input  wire  [7:0]         i_byte,
    input  wire                i_run,
    input  wire  [5:0]         i_rnd,
    input  wire                i_add,
    input  wire                i_init,
    input  wire  [2:0]         i_sel,
    output sha256_pkg::t_word  o_word
);
    sha256_pkg::t_word r_w [16];
    sha256_pkg::t_word r_h [8];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word w_new, t1, t2;

    assign w_new = sha256_pkg::sig1(r_w[14]) + r_w[9] + sha256_pkg::sig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + sha256_pkg::bsig1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::K_ROUND[i_rnd] + r_w[0];
    assign t2 = sha256_pkg::bsig0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_w[i_addr] <= {r_w[i_addr][23:0], i_byte};
        end else if (i_run) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
        if (i_run) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
        end else if (i_add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    assign o_word = r_h[i_sel];
endmodule
`default_nettype wire

>>> hdl/sha256_core.sv
// Hashing control: block assembly, padding, round sequencing, digest out.
`default_nettype none
module sha256_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire sha256_pkg::t_item i_item,
    input  wire                i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [31:0]        o_word,
    output logic [2:0]         o_index,
    output logic               o_last
);
    typedef enum logic [4:0] {
        ST_FILL = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_cnt;
    logic [5:0]  r_rnd;
    logic [63:0] r_len;
    logic        r_fin;
    logic        r_mark;
    logic        r_last_blk;
    logic [2:0]  r_oidx;

    logic       do_byte;
    logic [7:0] in_byte;
    logic [2:0] len_sel;

    assign o_pop   = (r_state == ST_FILL) && !i_empty;
    assign len_sel = r_cnt[2:0];

    always_comb begin
        do_byte = 1'b0;
        in_byte = 8'h00;
        unique case (r_state)
            ST_FILL: begin
                do_byte = o_pop && (i_item.finish == sha256_pkg::OP_ABSORB);
                in_byte = i_item.data;
            end
            ST_PAD: begin
                do_byte = 1'b1;
                if (!r_mark) begin
                    in_byte = 8'h80;
                end else if (r_last_blk && r_cnt >= 6'd56) begin
                    in_byte = r_len[{~len_sel, 3'b000} +: 8];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (o_pop && i_item.finish == sha256_pkg::OP_FINISH) begin
                    n_state = ST_PAD;
                end else if (do_byte && r_cnt == 6'd63) begin
                    n_state = ST_RUN;
                end
            end
            ST_PAD:  if (r_cnt == 6'd63) n_state = ST_RUN;
            ST_RUN:  if (r_rnd == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (!r_fin) n_state = ST_FILL;
                else if (r_last_blk) n_state = ST_OUT;
                else n_state = ST_PAD;
            end
            ST_OUT:  if (i_ready && r_oidx == 3'd7) n_state = ST_FILL;
            default: n_state = ST_FILL;
        endcase
    end

    sha256_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (do_byte),
        .i_addr  (r_cnt[5:2]),
        .i_byte  (in_byte),
        .i_run   (r_state == ST_RUN),
        .i_rnd   (r_rnd),
        .i_add   (r_state == ST_ADD),
        .i_init  (r_state == ST_OUT && i_ready && r_oidx == 3'd7),
        .i_sel   (r_oidx),
        .o_word  (o_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_cnt      <= '0;
            r_rnd      <= '0;
            r_len      <= '0;
            r_fin      <= 1'b0;
            r_mark     <= 1'b0;
            r_last_blk <= 1'b0;
            r_oidx     <= '0;
        end else begin
            r_state <= n_state;
            if (do_byte) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_state == ST_FILL) r_len <= r_len + 64'd8;
                if (r_state == ST_PAD) r_mark <= 1'b1;
            end
            if (r_state == ST_FILL && n_state == ST_PAD) begin
                r_fin      <= 1'b1;
                r_last_blk <= (r_cnt < 6'd56);
            end
            if (r_state == ST_ADD && n_state == ST_PAD) begin
                r_last_blk <= 1'b1;
            end
            if (r_state == ST_RUN) r_rnd <= r_rnd + 1'b1;
            if (r_state == ST_OUT && i_ready) begin
                r_oidx <= r_oidx + 1'b1;
                if (r_oidx == 3'd7) begin
                    r_len      <= '0;
                    r_fin      <= 1'b0;
                    r_mark     <= 1'b0;
                    r_last_blk <= 1'b0;
                    r_cnt      <= '0;
                end
            end
        end
    end

    assign o_valid = (r_state == ST_OUT);
    assign o_index = r_oidx;
    assign o_last  = (r_oidx == 3'd7);
endmodule
`default_nettype wire

>>> hdl/sha256_byte_stream_hasher.sv
// Top level: SHA-256 over a byte stream, digest out as eight 32-bit beats.
// Each absorb beat writes one byte into the block buffer; a full 64-byte block
// then runs 64 rounds of the single round unit, one per cycle, and is then
// folded into the chaining words. A finish beat pads out one or two padding
// blocks a byte at a time, then streams eight digest beats. A small input FIFO
// keeps accepting beats while the round unit is busy, until the FIFO is full.
`default_nettype none
module sha256_byte_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    sha256_pkg::t_item in_item, q_item;
    logic q_full, q_empty, q_pop;
    logic [31:0] d_word;
    logic [2:0]  d_idx;
    logic        d_last;

    assign in_item.finish = s_axis_tuser;
    assign in_item.data   = s_axis_tdata;
    assign s_axis_tready  = !q_full;

    sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && !q_full),
        .i_item  (in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (d_word),
        .o_index (d_idx),
        .o_last  (d_last)
    );

    assign m_axis_tdata = {5'd0, d_idx, d_word};
    assign m_axis_tlast = d_last;
endmodule
`default_nettype wire

>>> hdl/sha256_checker.sv
// Port checker for the SHA-256 hasher, bound to the top level.
`default_nettype none
module sha256_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped while stalled");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast not on word seven");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
        else $error("digest words not consecutive");
endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
